/* src/hsc_pkg.sv */
// shared types, constants and helper functions of the switch conductance block
package hsc_pkg;

    // shared multiplier operand and product
    typedef logic signed [33:0] t_op;
    typedef logic signed [67:0] t_prod;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM_ON,
        ST_NORM_OFF,
        ST_NORM_S,
        ST_REGION,
        ST_X2,
        ST_X3,
        ST_EXPO,
        ST_Y,
        ST_T,
        ST_HA,
        ST_HB,
        ST_HC,
        ST_SHIFT,
        ST_CUR_HI,
        ST_CUR_LO
    } t_state;

    typedef enum logic [1:0] {
        REG_ON    = 2'd0,
        REG_OFF   = 2'd1,
        REG_TRANS = 2'd2
    } t_region;

    // configuration register indexes
    localparam logic [2:0] CFG_OFF_LEVEL        = 3'd0;
    localparam logic [2:0] CFG_INV_SPAN         = 3'd1;
    localparam logic [2:0] CFG_INV_SPAN_HYS_ON  = 3'd2;
    localparam logic [2:0] CFG_OFF_HYS_LEVEL    = 3'd3;
    localparam logic [2:0] CFG_INV_SPAN_HYS_OFF = 3'd4;
    localparam logic [2:0] CFG_LOG_MID          = 3'd5;
    localparam logic [2:0] CFG_LOG_RATIO        = 3'd6;
    localparam logic [2:0] CFG_START_ON         = 3'd7;

    localparam logic signed [31:0] ONE_Q24   = 32'sd16777216;
    localparam logic signed [33:0] E_HI      = 34'sd201326592;   // 12.0 in Q8.24
    localparam logic signed [33:0] E_LO      = -34'sd385875968;  // -23.0 in Q8.24
    localparam logic [30:0]        L2E_Q30   = 31'd1549082005;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic [32:0]        ONE_Q30   = 33'd1073741824;
    localparam logic [3:0]         HORNER_N  = 4'd10;
    localparam logic [47:0]        G_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] off_level;
        logic signed [31:0] inv_span;
        logic signed [31:0] inv_span_hys_on;
        logic signed [31:0] off_hys_level;
        logic signed [31:0] inv_span_hys_off;
        logic signed [31:0] log_mid;
        logic signed [31:0] log_ratio;
        logic               start_on;
    } t_cfg;

    typedef struct packed {
        logic [47:0]        conductance;
        logic signed [55:0] branch_current;
        t_region            region;
        logic signed [31:0] normalized_state;
    } t_result;

    // floor(2^32 / n) for the horner divide steps
    function automatic logic [32:0] recip(input logic [3:0] n);
        logic [32:0] r;
        unique case (n)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

    // floor shift of a q.32 product down to q8.24, saturated to 32 bits
    function automatic logic signed [31:0] sat_norm(input t_prod p);
        logic signed [59:0] sh;
        sh = p[67:8];
        if (sh > 60'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (sh < -60'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return sh[31:0];
        end
    endfunction

endpackage

/* src/hsc_mul.sv */
// shared signed multiplier used by every multiply step of the sequencer
module hsc_mul
    import hsc_pkg::*;
(
    input  t_op   i_a,
    input  t_op   i_b,
    output t_prod o_p
);

    // full signed product
    assign o_p = i_a * i_b;

endmodule

/* src/hsc_seq.sv */
// sequencer and datapath registers stepping one item through the shared multiplier
module hsc_seq
    import hsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_control,
    input  logic signed [31:0] i_voltage,
    input  logic               i_init,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res
);

    t_state r_state, n_state;
    logic signed [31:0] r_c, n_c, r_v, n_v;
    logic               r_init, n_init;
    logic signed [31:0] r_hon, n_hon, r_hoff, n_hoff, r_s, n_s, r_last, n_last;
    t_region            r_region, n_region;
    logic signed [25:0] r_x, n_x, r_x2, n_x2;
    logic signed [27:0] r_q, n_q;
    logic signed [33:0] r_e, n_e;
    logic signed [7:0]  r_k, n_k;
    logic [29:0]        r_f, n_f, r_t, n_t;
    logic [32:0]        r_m, n_m, r_p, n_p, r_q0, n_q0;
    logic [3:0]         r_n, n_n;
    logic [47:0]        r_g, n_g;
    logic signed [50:0] r_hi, n_hi;

    t_op   w_a, w_b;
    t_prod w_p;

    logic signed [32:0] w_diff_on, w_diff_hoff;
    logic               w_on, w_off;
    logic signed [25:0] w_x_tr, w_x3;
    logic signed [37:0] w_y;
    logic [36:0]        w_rem;
    logic [32:0]        w_qc;
    logic signed [8:0]  w_sh;
    logic [5:0]         w_amt;
    logic [50:0]        w_wide;
    logic signed [59:0] w_sum;
    logic signed [55:0] w_cur;

    hsc_mul u_mul (
        .i_a (w_a),
        .i_b (w_b),
        .o_p (w_p)
    );

    assign w_diff_on   = 33'(r_c) - 33'(i_cfg.off_level);
    assign w_diff_hoff = 33'(r_c) - 33'(i_cfg.off_hys_level);

    // operand selection for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            ST_NORM_ON: begin
                w_a = 34'(w_diff_on);
                w_b = 34'(i_cfg.inv_span_hys_on);
            end
            ST_NORM_OFF: begin
                w_a = 34'(w_diff_hoff);
                w_b = 34'(i_cfg.inv_span_hys_off);
            end
            ST_NORM_S: begin
                w_a = 34'(w_diff_on);
                w_b = 34'(i_cfg.inv_span);
            end
            ST_X2: begin
                w_a = 34'(r_x);
                w_b = 34'(r_x);
            end
            ST_X3: begin
                w_a = 34'(r_x2);
                w_b = 34'(r_x);
            end
            ST_EXPO: begin
                w_a = 34'(r_q);
                w_b = 34'(i_cfg.log_ratio);
            end
            ST_Y: begin
                w_a = r_e;
                w_b = $signed({3'b000, L2E_Q30});
            end
            ST_T: begin
                w_a = $signed({4'b0000, r_f});
                w_b = $signed({4'b0000, LN2_Q30});
            end
            ST_HA: begin
                w_a = $signed({4'b0000, r_t});
                w_b = $signed({1'b0, r_m});
            end
            ST_HB: begin
                w_a = $signed({1'b0, r_p});
                w_b = $signed({1'b0, recip(r_n)});
            end
            ST_CUR_HI: begin
                w_a = 34'(r_v);
                w_b = $signed({10'd0, r_g[47:24]});
            end
            ST_CUR_LO: begin
                w_a = 34'(r_v);
                w_b = $signed({10'd0, r_g[23:0]});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // region decision and helper arithmetic
    assign w_on   = (r_s >= ONE_Q24) || ((r_last >= ONE_Q24) && (r_hon >= ONE_Q24));
    assign w_off  = (r_s <= 32'sd0) || ((r_last <= 32'sd0) && (r_hoff <= 32'sd0));
    assign w_x_tr = $signed({1'b0, r_s[23:0], 1'b0}) - 26'sd16777216;
    assign w_x3   = w_p[49:24];
    assign w_y    = w_p[61:24];
    assign w_rem  = 37'(r_p) - 37'(r_q0) * 37'(r_n);
    assign w_qc   = r_q0 + 33'(w_rem >= 37'(r_n)) + 33'(w_rem >= (37'(r_n) << 1));
    assign w_sh   = 9'(r_k) + 9'sd2;
    assign w_amt  = 6'(-w_sh);
    assign w_wide = 51'(r_m) << w_sh[4:0];
    assign w_sum  = (60'(r_hi) <<< 8) + 60'($signed(w_p[56:16]));
    assign w_cur  = (w_sum > 60'sd36028797018963967) ? 56'sh7F_FFFF_FFFF_FFFF :
                    (w_sum < -60'sd36028797018963968) ? 56'sh80_0000_0000_0000 :
                    w_sum[55:0];

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
        r_c      <= n_c;
        r_v      <= n_v;
        r_init   <= n_init;
        r_hon    <= n_hon;
        r_hoff   <= n_hoff;
        r_s      <= n_s;
        r_region <= n_region;
        r_x      <= n_x;
        r_x2     <= n_x2;
        r_q      <= n_q;
        r_e      <= n_e;
        r_k      <= n_k;
        r_f      <= n_f;
        r_t      <= n_t;
        r_m      <= n_m;
        r_p      <= n_p;
        r_q0     <= n_q0;
        r_n      <= n_n;
        r_g      <= n_g;
        r_hi     <= n_hi;
    end

    // next state and step results
    always_comb begin
        n_state  = r_state;
        n_c      = r_c;
        n_v      = r_v;
        n_init   = r_init;
        n_hon    = r_hon;
        n_hoff   = r_hoff;
        n_s      = r_s;
        n_last   = r_last;
        n_region = r_region;
        n_x      = r_x;
        n_x2     = r_x2;
        n_q      = r_q;
        n_e      = r_e;
        n_k      = r_k;
        n_f      = r_f;
        n_t      = r_t;
        n_m      = r_m;
        n_p      = r_p;
        n_q0     = r_q0;
        n_n      = r_n;
        n_g      = r_g;
        n_hi     = r_hi;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_c     = i_control;
                    n_v     = i_voltage;
                    n_init  = i_init;
                    n_state = ST_NORM_ON;
                end
            end
            ST_NORM_ON: begin
                n_hon   = sat_norm(w_p);
                n_state = ST_NORM_OFF;
            end
            ST_NORM_OFF: begin
                n_hoff  = sat_norm(w_p);
                n_state = ST_NORM_S;
            end
            ST_NORM_S: begin
                if (r_init) begin
                    n_s = i_cfg.start_on ? ONE_Q24 : 32'sd0;
                end else begin
                    n_s = sat_norm(w_p);
                end
                n_state = ST_REGION;
            end
            ST_REGION: begin
                n_last = r_s;
                if (w_on) begin
                    n_region = REG_ON;
                    n_x      = 26'sd16777216;
                end else if (w_off) begin
                    n_region = REG_OFF;
                    n_x      = -26'sd16777216;
                end else begin
                    n_region = REG_TRANS;
                    n_x      = w_x_tr;
                end
                n_state = ST_X2;
            end
            ST_X2: begin
                n_x2    = w_p[49:24];
                n_state = ST_X3;
            end
            ST_X3: begin
                n_q     = 28'(w_x3) - 28'(r_x) * 28'sd3;
                n_state = ST_EXPO;
            end
            ST_EXPO: begin
                n_e     = 34'($signed(w_p[58:26])) - 34'(i_cfg.log_mid);
                n_state = ST_Y;
            end
            ST_Y: begin
                // saturated exponent ranges skip the exponential
                if (r_e >= E_HI) begin
                    n_g     = G_MAX;
                    n_state = ST_CUR_HI;
                end else if (r_e < E_LO) begin
                    n_g     = '0;
                    n_state = ST_CUR_HI;
                end else begin
                    n_k     = w_y[37:30];
                    n_f     = w_y[29:0];
                    n_state = ST_T;
                end
            end
            ST_T: begin
                n_t     = w_p[59:30];
                n_m     = ONE_Q30;
                n_n     = HORNER_N;
                n_state = ST_HA;
            end
            ST_HA: begin
                n_p     = w_p[62:30];
                n_state = ST_HB;
            end
            ST_HB: begin
                n_q0    = w_p[64:32];
                n_state = ST_HC;
            end
            ST_HC: begin
                // quotient correction, then next horner term
                n_m = ONE_Q30 + w_qc;
                if (r_n == 4'd1) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_n     = r_n - 4'd1;
                    n_state = ST_HA;
                end
            end
            ST_SHIFT: begin
                if (w_sh >= 9'sd0) begin
                    if (w_sh >= 9'sd18) begin
                        n_g = G_MAX;
                    end else if (w_wide > 51'(G_MAX)) begin
                        n_g = G_MAX;
                    end else begin
                        n_g = w_wide[47:0];
                    end
                end else begin
                    n_g = 48'(r_m >> w_amt);
                end
                n_state = ST_CUR_HI;
            end
            ST_CUR_HI: begin
                if (w_p > 68'sd562949953421312) begin
                    n_hi = 51'sd562949953421312;
                end else if (w_p < -68'sd562949953421312) begin
                    n_hi = -51'sd562949953421312;
                end else begin
                    n_hi = w_p[50:0];
                end
                n_state = ST_CUR_LO;
            end
            ST_CUR_LO: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.conductance      = r_g;
    assign o_res.branch_current   = w_cur;
    assign o_res.region           = r_region;
    assign o_res.normalized_state = r_s;

endmodule

/* src/hysteretic_switch_conductance.sv */
// top level: configuration registers, sequencer and output register
//
//  channel   direction  payload (low bits first)                       tuser
//  s_axis    in         control[31:0], branch_voltage[63:32]           init_junction
//  m_axis    out        conductance, branch_current, normalized_state  region
//  cfg       in         i_cfg_index selects register, i_cfg_data value -
//
// on the normal path one item runs through the ten horner terms (three steps
// each) in the sequencer; when the exponent saturates those terms are skipped.
// the sequencer takes no new input until it has passed the current result on.
// the result sits in an output register, so the next item is taken while it
// waits. reset is synchronous, active low, and returns the configuration
// registers to defaults and the stored state to off.
module hysteretic_switch_conductance
    import hsc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cfg write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // control, branch_voltage
    input  logic [0:0]   s_axis_tuser,   // init_junction
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // conductance, branch_current, normalized_state
    output logic [1:0]   m_axis_tuser    // region
);

    t_cfg    r_cfg;
    t_result r_out;
    logic    r_out_valid;
    t_result w_res;
    logic    w_res_valid, w_res_ready;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_level        <= 32'sd0;
            r_cfg.inv_span         <= 32'sd65536;
            r_cfg.inv_span_hys_on  <= 32'sd65536;
            r_cfg.off_hys_level    <= 32'sd0;
            r_cfg.inv_span_hys_off <= 32'sd65536;
            r_cfg.log_mid          <= 32'sd115892897;
            r_cfg.log_ratio        <= -32'sd231785796;
            r_cfg.start_on         <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFF_LEVEL:        r_cfg.off_level        <= i_cfg_data;
                CFG_INV_SPAN:         r_cfg.inv_span         <= i_cfg_data;
                CFG_INV_SPAN_HYS_ON:  r_cfg.inv_span_hys_on  <= i_cfg_data;
                CFG_OFF_HYS_LEVEL:    r_cfg.off_hys_level    <= i_cfg_data;
                CFG_INV_SPAN_HYS_OFF: r_cfg.inv_span_hys_off <= i_cfg_data;
                CFG_LOG_MID:          r_cfg.log_mid          <= i_cfg_data;
                CFG_LOG_RATIO:        r_cfg.log_ratio        <= i_cfg_data;
                CFG_START_ON:         r_cfg.start_on         <= i_cfg_data[0];
                default:              r_cfg.start_on         <= r_cfg.start_on;
            endcase
        end
    end

    hsc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_control   (s_axis_tdata[31:0]),
        .i_voltage   (s_axis_tdata[63:32]),
        .i_init      (s_axis_tuser[0]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.normalized_state, r_out.branch_current, r_out.conductance};
    assign m_axis_tuser  = r_out.region;

endmodule

/* src/hsc_checker.sv */
// port level checks of the switch block, bound to the top level
module hsc_checker
    import hsc_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    logic signed [31:0] w_state;
    assign w_state = m_axis_tdata[135:104];

    // one item at a time: busy right after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // off region never reports a state at or above one
    a_off_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == REG_OFF) |-> (w_state < ONE_Q24))
        else $error("off region with full state");

    // transition region lies strictly between zero and one
    a_trans_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == REG_TRANS) |->
        (w_state > 32'sd0 && w_state < ONE_Q24))
        else $error("transition region out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind hysteretic_switch_conductance hsc_checker u_hsc_checker (.*);
